/* design/adcs_pkg.sv */
// Shared constants, register codes and payload types of the ADC scan averager.
`default_nettype none
package adcs_pkg;

	localparam int SAMPLES      = 100;
	localparam int NUM_CHANNELS = 4;

	localparam int CH_W      = 2;
	localparam int SAMPLE_W  = 12;
	localparam int CMD_W     = 8;
	localparam int AVG_W     = 14;
	localparam int SUM_W     = 21;
	localparam int CNT_W     = 8;
	localparam int TAKEN_W   = 7;
	localparam int IVL_W     = 6;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 8;

	// Reciprocal of SAMPLES, exact for every sum below 2^SUM_W.
	localparam int DIV_SHIFT = 28;
	localparam longint DIV_MUL_VAL = ((64'd1 << DIV_SHIFT) + SAMPLES - 1) / SAMPLES;
	localparam int DIV_MUL_W = $clog2(DIV_MUL_VAL + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CMD0     = 3'd0,
		REG_CMD1     = 3'd1,
		REG_CMD2     = 3'd2,
		REG_CMD3     = 3'd3,
		REG_SCALED   = 3'd4,
		REG_INTERVAL = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic                req_type;
		logic [SAMPLE_W-1:0] sample;
	} req_item_t;

	typedef struct packed {
		logic             busy_res;
		logic             cmd_valid;
		logic [CMD_W-1:0] cmd_byte;
		logic             avg_valid;
		logic [CH_W-1:0]  avg_channel;
		logic [AVG_W-1:0] avg_value;
	} res_item_t;

endpackage
`default_nettype wire

/* design/adcs_req_if.sv */
// Request channel carrying ticks and returned samples.
`default_nettype none
interface adcs_req_if;
	import adcs_pkg::*;
	logic      valid;
	logic      ready;
	req_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/adcs_res_if.sv */
// Result channel carrying one result per request.
`default_nettype none
interface adcs_res_if;
	import adcs_pkg::*;
	logic      valid;
	logic      ready;
	res_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/adcs_cfg_if.sv */
// Configuration write channel with register index and write data.
`default_nettype none
interface adcs_cfg_if;
	import adcs_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* design/adc_channel_scan_averager_core.sv */
// Top level of the four-channel ADC scan averager with burst averaging.
//
// The req channel takes scheduler ticks and returned converter samples; every
// request yields exactly one result on the res channel, in order. Ticks while
// idle advance the scan counter and may start a burst on the next channel,
// which raises cmd_valid with that channel's command byte. Samples during a
// burst are accumulated and the command is reissued until the sample count is
// reached, when the floor average is returned with avg_valid.
// One request is taken every cycle while the skid register is empty. All
// arithmetic for a request, including the reciprocal multiply for the
// average, sits between the request handshake and the output register.
// A skid register behind the output register lets one more request in while
// the receiver stalls; req.ready falls only once both are full.
// The cfg channel is always ready; the user must write it only while the block
// is idle, which the block does not enforce. Reset clears the scan and burst
// state and loads default command bytes, scaled channel 2 and tick interval 5.
`default_nettype none
module adc_channel_scan_averager_core (
	input  wire       clk,
	input  wire       arst_n,
	adcs_req_if.sink  req,
	adcs_res_if.source res,
	adcs_cfg_if.sink  cfg
);
	import adcs_pkg::*;

	localparam logic [DIV_MUL_W-1:0] DIV_MUL = DIV_MUL_W'(DIV_MUL_VAL);

	logic [CMD_W-1:0]   cmd_q [NUM_CHANNELS];
	logic [CH_W-1:0]    scaled_q;
	logic [IVL_W-1:0]   interval_q;

	logic [CNT_W-1:0]   tick_count_q;
	logic               burst_q;
	logic [CH_W-1:0]    burst_ch_q;
	logic [TAKEN_W-1:0] taken_q;
	logic [SUM_W-1:0]   sum_q;

	logic               out_valid_q;
	res_item_t          out_q;
	logic               skid_valid_q;
	res_item_t          skid_q;

	logic               acc;
	logic               out_free;
	res_item_t          res_new;

	logic [CNT_W-1:0]   tick_count_d;
	logic               burst_d;
	logic [CH_W-1:0]    burst_ch_d;
	logic [TAKEN_W-1:0] taken_d;
	logic [SUM_W-1:0]   sum_d;

	logic [IVL_W-1:0]   iv;
	logic [CNT_W-1:0]   cnt_inc;
	logic               start;
	logic [CH_W-1:0]    start_ch;
	logic [AVG_W-1:0]   smp_add;
	logic [SUM_W-1:0]   sum_add;
	logic [TAKEN_W-1:0] taken_inc;
	logic [SUM_W+DIV_MUL_W-1:0] prod;

	assign acc       = req.valid && req.ready;
	assign out_free  = !out_valid_q || res.ready;
	assign req.ready = !skid_valid_q;
	assign res.valid = out_valid_q;
	assign res.data  = out_q;
	assign cfg.ready = 1'b1;

	always_comb begin
		iv       = (interval_q == '0) ? IVL_W'(1) : interval_q;
		cnt_inc  = tick_count_q + CNT_W'(1);
		start    = 1'b0;
		start_ch = '0;
		for (int k = 0; k < NUM_CHANNELS; k++) begin
			if (cnt_inc == CNT_W'((k + 1) * iv)) begin
				start    = 1'b1;
				start_ch = CH_W'(k);
			end
		end

		if (burst_ch_q == scaled_q && {1'b0, burst_ch_q} < (CH_W + 1)'(NUM_CHANNELS)) begin
			smp_add = {req.data.sample, 2'b00};
		end else begin
			smp_add = AVG_W'(req.data.sample);
		end
		sum_add   = sum_q + SUM_W'(smp_add);
		taken_inc = taken_q + TAKEN_W'(1);
		prod      = (SUM_W + DIV_MUL_W)'(sum_add) * (SUM_W + DIV_MUL_W)'(DIV_MUL);

		tick_count_d = tick_count_q;
		burst_d      = burst_q;
		burst_ch_d   = burst_ch_q;
		taken_d      = taken_q;
		sum_d        = sum_q;
		res_new      = '0;

		if (!req.data.req_type) begin
			if (burst_q) begin
				res_new.busy_res = 1'b1;
			end else begin
				tick_count_d = (cnt_inc >= CNT_W'(NUM_CHANNELS * iv)) ? '0 : cnt_inc;
				if (start) begin
					burst_d            = 1'b1;
					burst_ch_d         = start_ch;
					taken_d            = '0;
					sum_d              = '0;
					res_new.busy_res   = 1'b1;
					res_new.cmd_valid  = 1'b1;
					res_new.cmd_byte   = cmd_q[start_ch];
				end
			end
		end else if (burst_q) begin
			sum_d   = sum_add;
			taken_d = taken_inc;
			if (taken_inc < TAKEN_W'(SAMPLES)) begin
				res_new.busy_res  = 1'b1;
				res_new.cmd_valid = 1'b1;
				res_new.cmd_byte  = cmd_q[burst_ch_q];
			end else begin
				burst_d             = 1'b0;
				res_new.avg_valid   = 1'b1;
				res_new.avg_channel = burst_ch_q;
				res_new.avg_value   = AVG_W'(prod >> DIV_SHIFT);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q[0]   <= CMD_W'(148);
			cmd_q[1]   <= CMD_W'(212);
			cmd_q[2]   <= CMD_W'(164);
			cmd_q[3]   <= CMD_W'(228);
			scaled_q   <= CH_W'(2);
			interval_q <= IVL_W'(5);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_CMD0:     cmd_q[0]   <= cfg.data;
				REG_CMD1:     cmd_q[1]   <= cfg.data;
				REG_CMD2:     cmd_q[2]   <= cfg.data;
				REG_CMD3:     cmd_q[3]   <= cfg.data;
				REG_SCALED:   scaled_q   <= cfg.data[CH_W-1:0];
				REG_INTERVAL: interval_q <= cfg.data[IVL_W-1:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
			burst_q      <= 1'b0;
			burst_ch_q   <= '0;
			taken_q      <= '0;
			sum_q        <= '0;
		end else if (acc) begin
			tick_count_q <= tick_count_d;
			burst_q      <= burst_d;
			burst_ch_q   <= burst_ch_d;
			taken_q      <= taken_d;
			sum_q        <= sum_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || acc;
			skid_valid_q <= 1'b0;
		end else if (acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (acc) begin
				out_q <= res_new;
			end
		end else if (acc) begin
			skid_q <= res_new;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result while the output register is empty");

	a_stall_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res.ready && acc) |=> skid_valid_q)
		else $error("request accepted during a stall was not held in the skid register");

	a_busy_excludes_avg: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.data.busy_res && res.data.avg_valid))
		else $error("result marks a burst both running and finished");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		burst_q |-> (taken_q < TAKEN_W'(SAMPLES)))
		else $error("burst still running with the full sample count taken");

endmodule
`default_nettype wire
